### design/phr_pkg.sv
// Shared types, constants and helper functions of the PPG heart-rate detector.
// Used by phr_interval, phr_div, ppg_heart_rate_detector and tb_top; depends on nothing.

package phr_pkg;

	// Field and register widths.
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned RATE_W   = 8;
	localparam int unsigned BPM_NUM  = 60000;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] FINGER_THR_RST = 16'd1000;
	localparam logic [CFG_W-1:0] MIN_IVAL_RST   = 16'd330;
	localparam logic [CFG_W-1:0] MAX_IVAL_RST   = 16'd1600;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_FINGER_THRESHOLD = 2'd0,
		CFG_MIN_INTERVAL     = 2'd1,
		CFG_MAX_INTERVAL     = 2'd2
	} cfg_reg_t;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_CROSS,
		ST_IVAL,
		ST_DIV,
		ST_RATE,
		ST_OUT
	} phr_state_t;

	// Result of the serial interval unit.
	typedef struct packed {
		logic                done;
		logic                ge_min;
		logic                le_max;
		logic [CFG_W-1:0]    interval;
	} phr_ival_res_t;

	// Result of the serial divider.
	typedef struct packed {
		logic                done;
		logic [CFG_W-1:0]    quot;
	} phr_div_res_t;

	// One bit of a serial subtraction x - y with borrow in.
	function automatic logic ser_diff(input logic x, input logic y, input logic bin);
		ser_diff = x ^ y ^ bin;
	endfunction

	// Borrow out of one bit of a serial subtraction x - y.
	function automatic logic ser_borrow(input logic x, input logic y, input logic bin);
		ser_borrow = (~x & y) | (~(x ^ y) & bin);
	endfunction

endpackage

### design/phr_interval.sv
// Bit-serial interval unit: forms now - last modulo 2^32 one bit per cycle,
// LSB first, and compares it serially against the beat window limits.
// Depends on phr_pkg.

module phr_interval (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [phr_pkg::TIME_W-1:0]        now_time,
	input  logic [phr_pkg::TIME_W-1:0]        last_time,
	input  logic [phr_pkg::CFG_W-1:0]         min_ival,
	input  logic [phr_pkg::CFG_W-1:0]         max_ival,
	output phr_pkg::phr_ival_res_t            res
);

	localparam int unsigned CNT_W = $clog2(phr_pkg::TIME_W);

	logic [phr_pkg::TIME_W-1:0] a_sr_q;
	logic [phr_pkg::TIME_W-1:0] b_sr_q;
	logic [phr_pkg::CFG_W-1:0]  min_sr_q;
	logic [phr_pkg::CFG_W-1:0]  max_sr_q;
	logic [phr_pkg::CFG_W-1:0]  ival_sr_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic                       sub_b_q;
	logic                       ge_b_q;
	logic                       le_b_q;
	logic                       d_bit;

	// Current bit of the interval.
	assign d_bit = phr_pkg::ser_diff(a_sr_q[0], b_sr_q[0], sub_b_q);

	// Control: one bit per cycle for the whole time width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(phr_pkg::TIME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand shift registers and the three borrow chains.
	always_ff @(posedge clk) begin
		if (start) begin
			a_sr_q   <= now_time;
			b_sr_q   <= last_time;
			min_sr_q <= min_ival;
			max_sr_q <= max_ival;
			sub_b_q  <= 1'b0;
			ge_b_q   <= 1'b0;
			le_b_q   <= 1'b0;
		end else if (busy_q) begin
			a_sr_q   <= {1'b0, a_sr_q[phr_pkg::TIME_W-1:1]};
			b_sr_q   <= {1'b0, b_sr_q[phr_pkg::TIME_W-1:1]};
			min_sr_q <= {1'b0, min_sr_q[phr_pkg::CFG_W-1:1]};
			max_sr_q <= {1'b0, max_sr_q[phr_pkg::CFG_W-1:1]};
			sub_b_q  <= phr_pkg::ser_borrow(a_sr_q[0], b_sr_q[0], sub_b_q);
			// interval - min and max - interval, borrow clear means in range.
			ge_b_q   <= phr_pkg::ser_borrow(d_bit, min_sr_q[0], ge_b_q);
			le_b_q   <= phr_pkg::ser_borrow(max_sr_q[0], d_bit, le_b_q);
			// Only the low bits of the interval are kept.
			if (cnt_q < CNT_W'(phr_pkg::CFG_W)) begin
				ival_sr_q <= {d_bit, ival_sr_q[phr_pkg::CFG_W-1:1]};
			end
		end
	end

	assign res.done     = done_q;
	assign res.ge_min   = ~ge_b_q;
	assign res.le_max   = ~le_b_q;
	assign res.interval = ival_sr_q;

endmodule

### design/phr_div.sv
// Restoring divider for 60000 / interval, one quotient bit per cycle.
// Depends on phr_pkg.

module phr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [phr_pkg::CFG_W-1:0]     divisor,
	output phr_pkg::phr_div_res_t         res
);

	localparam int unsigned N     = phr_pkg::CFG_W;
	localparam int unsigned CNT_W = $clog2(N);

	logic [N-1:0]     dvd_sr_q;
	logic [N-1:0]     dvs_q;
	logic [N-1:0]     rem_q;
	logic [N-1:0]     quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [N:0]       trial;
	logic             fits;

	// Bring down the next dividend bit and try the subtraction.
	assign trial = {rem_q, dvd_sr_q[N-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder, dividend and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_sr_q <= N'(phr_pkg::BPM_NUM);
			dvs_q    <= divisor;
			rem_q    <= '0;
			quot_q   <= '0;
		end else if (busy_q) begin
			dvd_sr_q <= {dvd_sr_q[N-2:0], 1'b0};
			quot_q   <= {quot_q[N-2:0], fits};
			if (fits) begin
				rem_q <= N'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[N-1:0];
			end
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;

endmodule

### design/ppg_heart_rate_detector.sv
// Top level of the PPG heart-rate detector, with sequencer, state and output register.
// Depends on phr_pkg, phr_interval and phr_div.

// One sample word is taken at a time. A sample without a finger or a seeding
// sample goes from the baseline step straight to the output step, and one with
// no upward zero crossing passes the crossing step first. A crossing also runs
// the bit-serial interval unit (32 time bits), and a crossing inside the beat
// window with a nonzero interval also runs the bit-serial divider (16 quotient
// bits) before the rate step. The next word can be accepted in the cycle after
// the result is loaded, once the sequencer is back in idle. The output register
// lets the result wait while the next word is taken in; only a second finished
// result waits for it.

module ppg_heart_rate_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [1:0]                        cfg_index,
	input  logic [phr_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [phr_pkg::SAMPLE_W-1:0]      ir_sample,
	input  logic [phr_pkg::TIME_W-1:0]        now_ms,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [phr_pkg::RATE_W-1:0]        pulse_rate,
	output logic                              beat_seen,
	output logic                              finger_on
);

	localparam int unsigned SW = phr_pkg::SAMPLE_W;
	localparam int unsigned RW = phr_pkg::RATE_W;

	phr_pkg::phr_state_t state_q, state_d;

	logic [phr_pkg::CFG_W-1:0]  thr_q, min_q, max_q;
	logic [SW-1:0]              ir_q;
	logic [phr_pkg::TIME_W-1:0] now_q;
	logic [SW-1:0]              dc_q;
	logic                       prev_neg_q;
	logic [phr_pkg::TIME_W-1:0] last_q;
	logic                       last_nz_q;
	logic                       rate_valid_q;
	logic                       finger_q;
	logic [RW-1:0]              rate_q;
	logic [RW-1:0]              bpm_q;
	logic                       beat_q;
	logic                       out_valid_q;
	logic [RW-1:0]              out_rate_q;
	logic                       out_beat_q;
	logic                       out_finger_q;

	logic                       no_finger;
	logic                       seed;
	logic                       ac_neg;
	logic                       crossing;
	logic                       in_window;
	logic [SW+3:0]              dc_sum;
	logic [RW+1:0]              smooth_sum;
	logic                       ival_start;
	logic                       div_start;
	logic                       out_load;

	phr_pkg::phr_ival_res_t     ival_res;
	phr_pkg::phr_div_res_t      div_res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= phr_pkg::FINGER_THR_RST;
			min_q <= phr_pkg::MIN_IVAL_RST;
			max_q <= phr_pkg::MAX_IVAL_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				phr_pkg::CFG_FINGER_THRESHOLD: thr_q <= cfg_data;
				phr_pkg::CFG_MIN_INTERVAL:     min_q <= cfg_data;
				phr_pkg::CFG_MAX_INTERVAL:     max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sample classification and baseline arithmetic.
	assign no_finger  = (ir_q < thr_q);
	assign seed       = !finger_q || (dc_q == '0);
	assign dc_sum     = {dc_q, 4'b0000} - {4'b0000, dc_q} + {4'b0000, ir_q};
	assign ac_neg     = (ir_q < dc_q);
	assign crossing   = prev_neg_q && !ac_neg;
	assign in_window  = last_nz_q && ival_res.ge_min && ival_res.le_max;
	assign smooth_sum = {1'b0, rate_q, 1'b0} + {2'b00, rate_q} + {2'b00, bpm_q};

	phr_interval u_ival (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ival_start),
		.now_time  (now_q),
		.last_time (last_q),
		.min_ival  (min_q),
		.max_ival  (max_q),
		.res       (ival_res)
	);

	phr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (ival_res.interval),
		.res     (div_res)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and unit starts.
	always_comb begin
		state_d    = state_q;
		ival_start = 1'b0;
		div_start  = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			phr_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = phr_pkg::ST_BASE;
				end
			end
			phr_pkg::ST_BASE: begin
				if (no_finger || seed) begin
					state_d = phr_pkg::ST_OUT;
				end else begin
					state_d = phr_pkg::ST_CROSS;
				end
			end
			phr_pkg::ST_CROSS: begin
				if (crossing) begin
					ival_start = 1'b1;
					state_d    = phr_pkg::ST_IVAL;
				end else begin
					state_d = phr_pkg::ST_OUT;
				end
			end
			phr_pkg::ST_IVAL: begin
				if (ival_res.done) begin
					if (!in_window) begin
						state_d = phr_pkg::ST_OUT;
					end else if (ival_res.interval == '0) begin
						state_d = phr_pkg::ST_RATE;
					end else begin
						div_start = 1'b1;
						state_d   = phr_pkg::ST_DIV;
					end
				end
			end
			phr_pkg::ST_DIV: begin
				if (div_res.done) begin
					state_d = phr_pkg::ST_RATE;
				end
			end
			phr_pkg::ST_RATE: begin
				state_d = phr_pkg::ST_OUT;
			end
			phr_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = phr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = phr_pkg::ST_IDLE;
			end
		endcase
	end

	// Detector state: baseline, crossing history and rate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q         <= '0;
			prev_neg_q   <= 1'b0;
			last_q       <= '0;
			last_nz_q    <= 1'b0;
			rate_valid_q <= 1'b0;
			finger_q     <= 1'b0;
			rate_q       <= '0;
		end else begin
			case (state_q)
				phr_pkg::ST_BASE: begin
					if (no_finger) begin
						rate_q       <= '0;
						dc_q         <= ir_q;
						prev_neg_q   <= 1'b0;
						last_q       <= '0;
						rate_valid_q <= 1'b0;
						finger_q     <= 1'b0;
					end else if (seed) begin
						finger_q     <= 1'b1;
						dc_q         <= ir_q;
						prev_neg_q   <= 1'b0;
						last_q       <= '0;
						rate_valid_q <= 1'b0;
					end else begin
						dc_q <= dc_sum[SW+3:4];
					end
				end
				phr_pkg::ST_CROSS: begin
					prev_neg_q <= ac_neg;
					if (crossing) begin
						last_nz_q <= (last_q != '0);
						last_q    <= now_q;
					end
				end
				phr_pkg::ST_RATE: begin
					rate_valid_q <= 1'b1;
					if (rate_valid_q) begin
						rate_q <= smooth_sum[RW+1:2];
					end else begin
						rate_q <= bpm_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Per-word working registers.
	always_ff @(posedge clk) begin
		if (state_q == phr_pkg::ST_IDLE && in_valid) begin
			ir_q   <= ir_sample;
			now_q  <= now_ms;
			beat_q <= 1'b0;
		end
		if (state_q == phr_pkg::ST_IVAL && ival_res.done) begin
			bpm_q <= {RW{1'b1}};
		end
		if (state_q == phr_pkg::ST_DIV && div_res.done) begin
			if (div_res.quot[phr_pkg::CFG_W-1:RW] != '0) begin
				bpm_q <= {RW{1'b1}};
			end else begin
				bpm_q <= div_res.quot[RW-1:0];
			end
		end
		if (state_q == phr_pkg::ST_RATE) begin
			beat_q <= 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rate_q   <= rate_q;
			out_beat_q   <= beat_q;
			out_finger_q <= finger_q;
		end
	end

	assign in_stall   = (state_q != phr_pkg::ST_IDLE);
	assign out_valid  = out_valid_q;
	assign pulse_rate = out_rate_q;
	assign beat_seen  = out_beat_q;
	assign finger_on  = out_finger_q;

	// A delivered beat always comes with a finger present.
	a_beat_finger: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beat_seen |-> finger_on)
		else $error("beat reported without finger present");

	// With no finger the rate and its valid flag stay cleared.
	a_no_finger_rate: assert property (@(posedge clk) disable iff (!arst_n)
		!finger_q |-> (rate_q == '0) && !rate_valid_q)
		else $error("rate held while no finger present");

	// An accepted word always starts with the baseline step.
	a_accept_base: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == phr_pkg::ST_BASE)
		else $error("accepted word did not enter baseline step");

	// The divider is started only for a crossing inside the window.
	a_div_window: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> ival_res.done && in_window)
		else $error("divider started outside the beat window");

endmodule

### tb/tb_top.sv
// Self-checking testbench of ppg_heart_rate_detector: directed and wave-shaped IR words,
// with a built-in rate predictor checked against every result word.
// Depends on phr_pkg and the ppg_heart_rate_detector RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int QUIET_LIMIT = 5000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] rate;
		logic       beat;
		logic       finger;
	} rate_word_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_write = 1'b0;
	logic [1:0]                   cfg_index = phr_pkg::CFG_FINGER_THRESHOLD;
	logic [phr_pkg::CFG_W-1:0]    cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [phr_pkg::SAMPLE_W-1:0] ir_sample = '0;
	logic [phr_pkg::TIME_W-1:0]   now_ms = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [phr_pkg::RATE_W-1:0]   pulse_rate;
	logic                         beat_seen;
	logic                         finger_on;

	// Predicted rate words still waiting for the block, oldest first.
	rate_word_t pending_rates[$];
	int mismatches = 0;
	int quiet_cycles = 0;

	// Idling control of both sides.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;

	// Predictor copy of the registers and the detector state.
	logic [15:0] thr_cfg = phr_pkg::FINGER_THR_RST;
	logic [15:0] min_gap_cfg = phr_pkg::MIN_IVAL_RST;
	logic [15:0] max_gap_cfg = phr_pkg::MAX_IVAL_RST;
	logic [15:0] base_level = '0;
	logic        dip_seen = 1'b0;
	logic [31:0] last_cross_ms = '0;
	logic        rate_known = 1'b0;
	logic        finger_seen = 1'b0;
	logic [7:0]  smooth_rate = '0;

	ppg_heart_rate_detector DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.ir_sample  (ir_sample),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pulse_rate (pulse_rate),
		.beat_seen  (beat_seen),
		.finger_on  (finger_on)
	);

	always #1 clk = ~clk;

	// Forget the beat history; a new rate must be built from scratch.
	function automatic void clear_beat_history();
		dip_seen = 1'b0;
		last_cross_ms = '0;
		rate_known = 1'b0;
	endfunction

	// Advance the predicted detector state by one IR word and return its result word.
	function automatic rate_word_t predict_word(input logic [15:0] ir, input logic [31:0] t);
		rate_word_t  w;
		logic        below;
		logic [31:0] span;
		int unsigned bpm;
		w.beat = 1'b0;
		if (ir < thr_cfg) begin
			smooth_rate = '0;
			base_level = ir;
			clear_beat_history();
			finger_seen = 1'b0;
		end else if (!finger_seen || base_level == 0) begin
			finger_seen = 1'b1;
			base_level = ir;
			clear_beat_history();
		end else begin
			base_level = 16'((32'(base_level) * 32'd15 + 32'(ir)) / 32'd16);
			below = ir < base_level;
			// An upward zero crossing of the AC part is a beat candidate.
			if (dip_seen && !below) begin
				span = t - last_cross_ms;
				if (last_cross_ms != 0 && span >= 32'(min_gap_cfg) &&
						span <= 32'(max_gap_cfg)) begin
					if (span == 0)
						bpm = 255;
					else
						bpm = 60000 / span;
					if (bpm > 255)
						bpm = 255;
					if (rate_known)
						smooth_rate = 8'((32'(smooth_rate) * 3 + bpm) / 4);
					else
						smooth_rate = 8'(bpm);
					rate_known = 1'b1;
					w.beat = 1'b1;
				end
				last_cross_ms = t;
			end
			dip_seen = below;
		end
		w.rate = smooth_rate;
		w.finger = finger_seen;
		return w;
	endfunction

	// Check each result word against the oldest prediction, then predict for a new input word.
	always @(posedge clk) begin
		rate_word_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_rates.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result word: rate %0d beat %0d finger %0d",
							pulse_rate, beat_seen, finger_on);
				end else begin
					e = pending_rates.pop_front();
					if (pulse_rate !== e.rate || beat_seen !== e.beat ||
							finger_on !== e.finger) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"mismatch: rate %0d beat %0d finger %0d,",
								" expected %0d %0d %0d"},
								pulse_rate, beat_seen, finger_on,
								e.rate, e.beat, e.finger);
					end
				end
			end
			if (in_valid && !in_stall)
				pending_rates.push_back(predict_word(ir_sample, now_ms));
		end
	end

	// Receiver: random stalls, or a long hold-off while hold_left runs down.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog on cycles in which no word moves on either side.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offer one IR word after a random gap and wait until it is taken.
	task automatic send_word(input logic [15:0] ir, input logic [31:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		ir_sample <= ir;
		now_ms <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// A dip below the baseline followed by a peak: the peak is an upward crossing.
	task automatic send_pulse(input logic [15:0] low, input logic [31:0] t_low,
			input logic [31:0] t_peak);
		send_word(low, t_low);
		send_word(16'hFFFF, t_peak);
	endtask

	// Lower valid and wait until every predicted word has arrived.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_rates.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input phr_pkg::cfg_reg_t idx, input logic [15:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			phr_pkg::CFG_FINGER_THRESHOLD: thr_cfg = value;
			phr_pkg::CFG_MIN_INTERVAL:     min_gap_cfg = value;
			phr_pkg::CFG_MAX_INTERVAL:     max_gap_cfg = value;
			default: ;
		endcase
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		wait_idle();
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		@(negedge clk);
	endtask

	// Triangle-shaped pulse wave with jitter, finger lifts, noise and time jumps.
	task automatic send_wave(input int count);
		logic [31:0] t;
		int unsigned period, base, amp, ph, lvl, ir, r;
		t = $urandom();
		if ($urandom_range(1) == 0)
			t = 32'hFFFF_F000 + $urandom_range(3000);
		period = $urandom_range(1800, 250);
		base = $urandom_range(30000, 1000);
		amp = $urandom_range(17000, 200);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 2) begin
				period = $urandom_range(1800, 250);
				base = $urandom_range(30000, 1000);
				amp = $urandom_range(17000, 200);
			end
			t = t + $urandom_range(60, 8);
			if ($urandom_range(199) == 0)
				t = $urandom();
			r = $urandom_range(99);
			if (r < 4) begin
				ir = $urandom_range(65535);
			end else if (r < 7 && thr_cfg != 0) begin
				ir = $urandom_range(thr_cfg - 1);
			end else begin
				ph = t % period;
				if (ph < period / 2)
					lvl = ph * 2048 / period;
				else
					lvl = 2048 - ph * 2048 / period;
				ir = base + amp * lvl / 1024 + $urandom_range(63);
				if (ir > 65535)
					ir = 65535;
			end
			send_word(16'(ir), t);
		end
	endtask

	// No finger, seeding, first crossing, window edges and time wrap, default registers.
	task automatic test_beat_window();
		send_word(16'h0000, 32'h0000_0000);
		send_word(16'hFFFF, 32'hFFFF_FFFF);
		send_pulse(16'd1000, 32'hFFFF_FE00, 32'hFFFF_FF00);
		send_pulse(16'd1000, 32'hFFFF_FF80, 32'hFFFF_FF00 + 32'd600);
		send_pulse(16'd1000, 32'h0000_0300, 32'hFFFF_FF00 + 32'd800);
		send_pulse(16'd1000, 32'h0000_0400, 32'hFFFF_FF00 + 32'd2800);
		send_pulse(16'd1000, 32'h0000_0B00, 32'hFFFF_FF00 + 32'd3130);
	endtask

	// Saturated rates, zero interval, crossing at time zero and an empty window.
	task automatic test_rate_saturation();
		wait_idle();
		write_reg(phr_pkg::CFG_MIN_INTERVAL, 16'd0);
		write_reg(phr_pkg::CFG_MAX_INTERVAL, 16'hFFFF);
		send_pulse(16'd1000, 32'd4000, 32'd5000);
		send_pulse(16'd1000, 32'd5000, 32'd5000);
		send_pulse(16'd1000, 32'd5040, 32'd5050);
		send_pulse(16'd1000, 32'd6000, 32'd0);
		send_pulse(16'd1000, 32'd100, 32'd400);
		wait_idle();
		write_reg(phr_pkg::CFG_MIN_INTERVAL, 16'd1);
		write_reg(phr_pkg::CFG_MAX_INTERVAL, 16'd1);
		send_pulse(16'd1000, 32'd400, 32'd401);
		wait_idle();
		write_reg(phr_pkg::CFG_MIN_INTERVAL, 16'd2000);
		write_reg(phr_pkg::CFG_MAX_INTERVAL, 16'd500);
		send_pulse(16'd1000, 32'd900, 32'd1200);
	endtask

	// Threshold extremes, and a finger present on a zero baseline.
	task automatic test_finger_threshold();
		wait_idle();
		write_reg(phr_pkg::CFG_FINGER_THRESHOLD, 16'hFFFF);
		send_word(16'd100, 32'd1300);
		wait_idle();
		write_reg(phr_pkg::CFG_FINGER_THRESHOLD, 16'h0000);
		send_word(16'h0000, 32'd1400);
		send_word(16'hFFFF, 32'd1500);
	endtask

	task automatic test_waveform(input logic [15:0] thr, input logic [15:0] min_gap,
			input logic [15:0] max_gap, input int count);
		wait_idle();
		write_reg(phr_pkg::CFG_FINGER_THRESHOLD, thr);
		write_reg(phr_pkg::CFG_MIN_INTERVAL, min_gap);
		write_reg(phr_pkg::CFG_MAX_INTERVAL, max_gap);
		send_wave(count);
	endtask

	// The receiver holds off for a long stretch so the block fills and stalls its input.
	task automatic test_receiver_hold();
		wait_idle();
		@(posedge clk);
		hold_left = 600;
		@(negedge clk);
		send_wave(40);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idling(24, 53);
		test_beat_window();
		test_rate_saturation();
		test_finger_threshold();
		test_waveform(phr_pkg::FINGER_THR_RST, phr_pkg::MIN_IVAL_RST,
			phr_pkg::MAX_IVAL_RST, 380);
		test_receiver_hold();

		set_idling(53, 24);
		test_waveform(16'($urandom_range(4000)), 16'($urandom_range(700, 1)),
			16'($urandom_range(3000, 600)), 350);

		set_idling(0, 0);
		test_waveform(16'($urandom_range(2000, 500)), 16'd1, 16'hFFFF, 350);

		wait_idle();
		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending_rates.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
